// File: design/quadratic_root_solver_defines.svh
// Assertion macros used by the checker of the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define QRS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("quadratic_root_solver check failed");

// Check that cons holds in the cycle after ante holds.
`define QRS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("quadratic_root_solver check failed");

`endif

// File: design/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
`default_nettype none
package qrs_pkg;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 16;
	localparam int DISC_W    = 2 * COEF_W + 2;
	localparam int COUNT_W   = 2;
	localparam int ROOT_W    = 35;
	localparam int RAD_W     = DISC_W + 2 * FRAC_BITS;
	localparam int SQ_W      = RAD_W / 2;
	localparam int REM_W     = SQ_W + 3;
	localparam int NUM_W     = SQ_W + 2;
	localparam int QW        = NUM_W - 1;
	localparam int DEN_W     = COEF_W + 1;
	localparam int DREM_W    = DEN_W + 1;
	localparam int DIV_LAT   = QW + 2;
	localparam int IN_W      = 3 * COEF_W;
	localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W     = DISC_W + COUNT_W + 2 * ROOT_W + 1;
	localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [COUNT_W-1:0] CNT_NONE = 2'd0;
	localparam logic [COUNT_W-1:0] CNT_ONE  = 2'd1;
	localparam logic [COUNT_W-1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic signed [DISC_W-1:0] disc;
		logic [COUNT_W-1:0]       count;
		logic                     degen;
		logic                     go;
	} side_t;
endpackage
`default_nettype wire

// File: design/qrs_divider.sv
// Pipelined signed divider by 2a, one quotient bit per stage, truncating toward zero.
`default_nettype none
module qrs_divider
	import qrs_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic signed [NUM_W-1:0]  num,
	input  wire logic signed [COEF_W-1:0] coef_a,
	output logic signed [ROOT_W-1:0]      quot
);
	logic [QW-1:0]     n_s   [0:QW];
	logic [DREM_W-1:0] rem_s [0:QW];
	logic [DEN_W-1:0]  den_s [0:QW];
	logic              neg_s [0:QW];
	logic signed [ROOT_W-1:0] quot_s;
	logic [NUM_W-1:0]    num_mag;
	logic [COEF_W-1:0]   a_mag;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign a_mag   = coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);

	// Take magnitudes and the quotient sign
	always_ff @(posedge clk) begin
		if (en) begin
			n_s[0]   <= num_mag[QW-1:0];
			rem_s[0] <= '0;
			den_s[0] <= {a_mag, 1'b0};
			neg_s[0] <= num[NUM_W-1] ^ coef_a[COEF_W-1];
		end
	end

	// Restoring division, one bit per stage
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [DREM_W-1:0] trial;
		logic              fit;
		assign trial = {rem_s[k-1][DREM_W-2:0], n_s[k-1][QW-1]};
		assign fit   = trial >= {1'b0, den_s[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fit ? DREM_W'(trial - {1'b0, den_s[k-1]}) : trial;
				n_s[k]   <= {n_s[k-1][QW-2:0], fit};
				den_s[k] <= den_s[k-1];
				neg_s[k] <= neg_s[k-1];
			end
		end
	end

	// Apply the sign
	always_ff @(posedge clk) begin
		if (en) begin
			quot_s <= neg_s[QW] ? ROOT_W'(-$signed({1'b0, n_s[QW]}))
			                    : ROOT_W'($signed({1'b0, n_s[QW]}));
		end
	end

	assign quot = quot_s;
endmodule
`default_nettype wire

// File: design/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, pipelined square root, two dividers.
//
//  channel  | direction | payload
//  s_axis   | in        | coef_a, coef_b, coef_c
//  m_axis   | out       | discriminant, root_count, root_plus, root_minus, degenerate
//
// One request is taken every cycle while the output is not stalled; the pipeline runs through
// the product and discriminant stages, the 33-stage bit-per-stage square root and the 34-bit bit-per-stage dividers.
// Reset clears only the valid bits; data registers carry no reset.
// A stall at the output freezes every stage at once, so nothing is lost or repeated.
`default_nettype none
module quadratic_root_solver
	import qrs_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	// coef_a [15:0], coef_b [31:16], coef_c [47:32]
	input  wire logic [S_TDATA_W-1:0] s_tdata,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// discriminant [33:0], root_count [35:34], root_plus [70:36],
	// root_minus [105:71], degenerate [106], zero fill above
	output logic [M_TDATA_W-1:0]      m_tdata
);
	localparam int NSTG = 2 + SQ_W + DIV_LAT;

	typedef struct packed {
		logic [RAD_W-1:0]         rad;
		logic [REM_W-1:0]         rem;
		logic [SQ_W-1:0]          root;
		logic signed [NUM_W-1:0]  nb;
		logic signed [COEF_W-1:0] a;
		side_t                    side;
	} sq_t;

	logic en;
	logic v_q [0:NSTG-1];

	logic signed [COEF_W-1:0]   a_in, b_in, c_in;
	logic signed [2*COEF_W-1:0] bb_s1, ac_s1;
	logic signed [COEF_W-1:0]   a_s1, b_s1;
	sq_t sq_s [0:SQ_W];
	side_t side_d [0:DIV_LAT-1];
	logic signed [DISC_W-1:0] disc_c;
	logic signed [NUM_W-1:0]  num_p, num_m;
	logic signed [ROOT_W-1:0] q_p, q_m, rp, rm;
	side_t side_o;

	assign en       = !v_q[NSTG-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_q[NSTG-1];

	assign a_in = s_tdata[COEF_W-1:0];
	assign b_in = s_tdata[2*COEF_W-1:COEF_W];
	assign c_in = s_tdata[3*COEF_W-1:2*COEF_W];

	// Advance the valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTG; i++) v_q[i] <= 1'b0;
		end else if (en) begin
			v_q[0] <= s_tvalid;
			for (int i = 1; i < NSTG; i++) v_q[i] <= v_q[i-1];
		end
	end

	// Form the products
	always_ff @(posedge clk) begin
		if (en) begin
			bb_s1 <= b_in * b_in;
			ac_s1 <= a_in * c_in;
			a_s1  <= a_in;
			b_s1  <= b_in;
		end
	end

	// Form the discriminant, classify it, load the square root radicand
	assign disc_c = DISC_W'(bb_s1) - (DISC_W'(ac_s1) <<< 2);
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s[0].side.disc  <= disc_c;
			sq_s[0].side.degen <= (a_s1 == '0);
			sq_s[0].side.go    <= !disc_c[DISC_W-1] && (a_s1 != '0);
			priority if (disc_c[DISC_W-1]) sq_s[0].side.count <= CNT_NONE;
			else if (disc_c == '0)         sq_s[0].side.count <= CNT_ONE;
			else                           sq_s[0].side.count <= CNT_TWO;
			sq_s[0].rad  <= disc_c[DISC_W-1] ? '0 : {disc_c, {(2*FRAC_BITS){1'b0}}};
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].nb   <= -(NUM_W'(b_s1) <<< FRAC_BITS);
			sq_s[0].a    <= a_s1;
		end
	end

	// Square root, one result bit per stage
	for (genvar k = 1; k <= SQ_W; k++) begin : g_sqrt
		logic [REM_W-1:0] cur, trial;
		logic             fit;
		assign cur   = {sq_s[k-1].rem[REM_W-3:0], sq_s[k-1].rad[RAD_W-1 -: 2]};
		assign trial = REM_W'({sq_s[k-1].root, 2'b01});
		assign fit   = cur >= trial;
		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[k].rad  <= {sq_s[k-1].rad[RAD_W-3:0], 2'b00};
				sq_s[k].rem  <= fit ? REM_W'(cur - trial) : cur;
				sq_s[k].root <= {sq_s[k-1].root[SQ_W-2:0], fit};
				sq_s[k].nb   <= sq_s[k-1].nb;
				sq_s[k].a    <= sq_s[k-1].a;
				sq_s[k].side <= sq_s[k-1].side;
			end
		end
	end

	assign num_p = sq_s[SQ_W].nb + $signed({2'b00, sq_s[SQ_W].root});
	assign num_m = sq_s[SQ_W].nb - $signed({2'b00, sq_s[SQ_W].root});

	qrs_divider u_div_plus (
		.clk(clk), .en(en), .num(num_p), .coef_a(sq_s[SQ_W].a), .quot(q_p)
	);
	qrs_divider u_div_minus (
		.clk(clk), .en(en), .num(num_m), .coef_a(sq_s[SQ_W].a), .quot(q_m)
	);

	// Carry the classification alongside the dividers
	always_ff @(posedge clk) begin
		if (en) begin
			side_d[0] <= sq_s[SQ_W].side;
			for (int i = 1; i < DIV_LAT; i++) side_d[i] <= side_d[i-1];
		end
	end

	// Drop the roots when there are none or a is zero
	assign side_o = side_d[DIV_LAT-1];
	assign rp     = side_o.go ? q_p : '0;
	assign rm     = side_o.go ? q_m : '0;
	assign m_tdata = M_TDATA_W'({side_o.degen, rm, rp, side_o.count, side_o.disc});
endmodule
`default_nettype wire

// File: design/qrs_checker.sv
// Port-level checker of the quadratic root solver, bound to the top level.
`default_nettype none
`include "quadratic_root_solver_defines.svh"
module qrs_checker
	import qrs_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata
);
	logic [COUNT_W-1:0] cnt;
	logic               dgn;
	logic [ROOT_W-1:0]  r_p, r_m;
	assign cnt = m_tdata[DISC_W+COUNT_W-1:DISC_W];
	assign r_p = m_tdata[DISC_W+COUNT_W+ROOT_W-1:DISC_W+COUNT_W];
	assign r_m = m_tdata[DISC_W+COUNT_W+2*ROOT_W-1:DISC_W+COUNT_W+ROOT_W];
	assign dgn = m_tdata[DISC_W+COUNT_W+2*ROOT_W];

	`QRS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid)
	`QRS_ASSERT_NEXT(a_hold_data, m_tvalid && !m_tready, $stable(m_tdata))
	`QRS_ASSERT_NOW(a_ready_follows, 1'b1, s_tready == (!m_tvalid || m_tready))
	`QRS_ASSERT_NOW(a_no_roots_zero, m_tvalid && (dgn || cnt == CNT_NONE),
		r_p == '0 && r_m == '0)
	`QRS_ASSERT_NOW(a_double_equal, m_tvalid && cnt == CNT_ONE, r_p == r_m)
endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
